FILE: hw/rtl/gss_pkg.sv
package gss_pkg;

	localparam int POS_W = 32;
	localparam int VAL_W = 47;
	localparam int TOL_W = 31;

	localparam logic [TOL_W-1:0] TOL_RESET = 31'd66;

	// Golden ratio conjugate 0.618 in Q0.16, truncated.
	localparam logic [15:0] GOLD_Q16 = 16'd40503;
	localparam int GOLD_FRAC = 16;

	localparam logic [VAL_W-1:0] VALUE_MAX = {VAL_W{1'b1}};

	// One search interval travelling around the cell ring.
	typedef struct packed {
		logic valid;
		logic done;
		logic signed [POS_W-1:0] lo;
		logic signed [POS_W-1:0] hi;
	} gss_tok_t;

endpackage

FILE: hw/rtl/golden_section_minimizer_top.sv
// Timing: each narrowing step passes through the registered stages of one cell in a ring of
// NUM_CELLS cells; after the final width test the request finishes its trip round the ring, then
// passes the finishing pipeline to the output, and each pass that finds the finishing stage
// still busy costs it one more trip round the ring.
// Throughput: one request in the ring at a time; the next is accepted once the previous
// one leaves the ring. Reset: clears the ring and valid flags, tolerance becomes 66.
module golden_section_minimizer_top import gss_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int NUM_CELLS = 2
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [TOL_W-1:0]        cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [POS_W-1:0] left_end,
	input  logic signed [POS_W-1:0] right_end,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [POS_W-1:0] min_position,
	output logic [VAL_W-1:0]        min_value
);

	logic [TOL_W-1:0] tol_q;
	logic             ring_busy_q;
	logic             in_fire;
	logic             fin_free;
	logic             leave;
	gss_tok_t         ring_in;
	gss_tok_t         last;
	gss_tok_t         link [NUM_CELLS];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_valid) begin
			tol_q <= cfg_data;
		end
	end

	assign in_ready = !ring_busy_q;
	assign in_fire  = in_valid && in_ready;
	assign last     = link[NUM_CELLS-1];

	// A finished request keeps circling until the finishing pipeline is empty.
	assign leave = last.valid && last.done && fin_free;

	always_comb begin
		if (in_fire) begin
			ring_in.valid = 1'b1;
			ring_in.done  = 1'b0;
			ring_in.lo    = left_end;
			ring_in.hi    = right_end;
		end else if (leave) begin
			ring_in = '0;
		end else begin
			ring_in = last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_busy_q <= 1'b0;
		end else if (in_fire) begin
			ring_busy_q <= 1'b1;
		end else if (leave) begin
			ring_busy_q <= 1'b0;
		end
	end

	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		if (i == 0) begin : g_first
			gss_cell #(
				.FRAC_BITS(FRAC_BITS)
			) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.tol    (tol_q),
				.tok_in (ring_in),
				.tok_out(link[i])
			);
		end else begin : g_next
			gss_cell #(
				.FRAC_BITS(FRAC_BITS)
			) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.tol    (tol_q),
				.tok_in (link[i-1]),
				.tok_out(link[i])
			);
		end
	end

	gss_finish #(
		.FRAC_BITS(FRAC_BITS)
	) u_finish (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (leave),
		.tok         (last),
		.out_ready   (out_ready),
		.free        (fin_free),
		.out_valid   (out_valid),
		.min_position(min_position),
		.min_value   (min_value)
	);

endmodule

FILE: hw/rtl/gss_cell.sv
module gss_cell import gss_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [TOL_W-1:0] tol,
	input  gss_tok_t         tok_in,
	output gss_tok_t         tok_out
);

	localparam logic [POS_W:0] TWO_Q = 33'd2 << FRAC_BITS;

	logic signed [POS_W:0] width;
	logic                  cont;
	gss_tok_t              tok_s1;
	gss_tok_t              tok_s2;
	gss_tok_t              tok_s3;
	gss_tok_t              nxt;
	logic [POS_W-1:0]      width_s1;
	logic [POS_W-1:0]      d_s2;
	logic [POS_W+15:0]     prod;
	logic [POS_W-1:0]      x1;
	logic [POS_W-1:0]      x2;
	logic [POS_W:0]        dif1;
	logic [POS_W:0]        dif2;
	logic [POS_W:0]        neg1;
	logic [POS_W:0]        neg2;
	logic [POS_W-1:0]      a1;
	logic [POS_W-1:0]      a2;

	// Stage 1: interval width and the termination test.
	always_comb begin
		width = {tok_in.hi[POS_W-1], tok_in.hi} - {tok_in.lo[POS_W-1], tok_in.lo};
		cont  = tok_in.valid && !tok_in.done && (width > $signed({2'b00, tol}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1   <= '0;
			width_s1 <= '0;
		end else begin
			tok_s1   <= '{valid: tok_in.valid, done: !cont, lo: tok_in.lo, hi: tok_in.hi};
			width_s1 <= width[POS_W-1:0];
		end
	end

	// Stage 2: step length d = width * 0.618, truncated.
	assign prod = (POS_W + 16)'(width_s1) * (POS_W + 16)'(GOLD_Q16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s2 <= '0;
			d_s2   <= '0;
		end else begin
			tok_s2 <= tok_s1;
			d_s2   <= prod[POS_W+GOLD_FRAC-1:GOLD_FRAC];
		end
	end

	// Stage 3: interior points stay inside the interval, so 32-bit wrap is exact.
	always_comb begin
		x1   = tok_s2.hi - d_s2;
		x2   = tok_s2.lo + d_s2;
		dif1 = {x1[POS_W-1], x1} - TWO_Q;
		dif2 = {x2[POS_W-1], x2} - TWO_Q;
		neg1 = '0 - dif1;
		neg2 = '0 - dif2;
		a1   = dif1[POS_W] ? neg1[POS_W-1:0] : dif1[POS_W-1:0];
		a2   = dif2[POS_W] ? neg2[POS_W-1:0] : dif2[POS_W-1:0];
		nxt  = tok_s2;
		if (tok_s2.valid && !tok_s2.done) begin
			if (a1 < a2) begin
				nxt.hi = x2;
			end else if (a1 > a2) begin
				nxt.lo = x1;
			end else begin
				nxt.lo = x1;
				nxt.hi = x2;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s3 <= '0;
		end else begin
			tok_s3 <= nxt;
		end
	end

	assign tok_out = tok_s3;

endmodule

FILE: hw/rtl/gss_finish.sv
module gss_finish import gss_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  gss_tok_t                tok,
	input  logic                    out_ready,
	output logic                    free,
	output logic                    out_valid,
	output logic signed [POS_W-1:0] min_position,
	output logic [VAL_W-1:0]        min_value
);

	localparam logic [POS_W:0] TWO_Q   = 33'd2 << FRAC_BITS;
	localparam logic [63:0]    THREE_Q = 64'd3 << FRAC_BITS;

	logic [POS_W:0]   sum;
	logic [POS_W:0]   dif;
	logic [POS_W:0]   neg;
	logic [POS_W-1:0] ad;
	logic [63:0]      prod;
	logic [63:0]      val;
	logic             sat;

	logic             v_s1;
	logic             v_s2;
	logic             v_s3;
	logic [POS_W-1:0] mid_s1;
	logic [POS_W-1:0] mid_s2;
	logic [POS_W-1:0] mid_s3;
	logic [POS_W-1:0] ad_s2;
	logic [63:0]      prod_s3;
	logic             out_valid_q;
	logic [POS_W-1:0] min_position_q;
	logic [VAL_W-1:0] min_value_q;

	always_comb begin
		sum  = {tok.lo[POS_W-1], tok.lo} + {tok.hi[POS_W-1], tok.hi};
		dif  = {mid_s1[POS_W-1], mid_s1} - TWO_Q;
		neg  = '0 - dif;
		ad   = dif[POS_W] ? neg[POS_W-1:0] : dif[POS_W-1:0];
		prod = {32'd0, ad_s2} * {32'd0, ad_s2};
		val  = (prod_s3 >> FRAC_BITS) + THREE_Q;
		sat  = |val[63:VAL_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s3) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Floor of the midpoint is the sum shifted right arithmetically.
	always_ff @(posedge clk) begin
		mid_s1  <= sum[POS_W:1];
		mid_s2  <= mid_s1;
		ad_s2   <= ad;
		mid_s3  <= mid_s2;
		prod_s3 <= prod;
		if (v_s3) begin
			min_position_q <= mid_s3;
			min_value_q    <= sat ? VALUE_MAX : val[VAL_W-1:0];
		end
	end

	assign free         = !(v_s1 || v_s2 || v_s3 || out_valid_q);
	assign out_valid    = out_valid_q;
	assign min_position = min_position_q;
	assign min_value    = min_value_q;

endmodule
